// ===== rtl/bsmd_pkg.sv =====
// Shared types and constants for the byte stream message deframer.
// Used by bsmd_parse, bsmd_rsp_fifo and byte_stream_message_deframer.
package bsmd_pkg;

   // Default cap on delivered payload bytes per frame
   localparam int MaxPayloadDefault = 4096;

   // Depth of the result queue: room for two results per item plus slack
   localparam int RspDepth = 4;

   localparam logic [7:0] CharLf = 8'h0A;
   localparam logic [7:0] CharCr = 8'h0D;

   typedef enum logic {
      OP_BYTE  = 1'b0,
      OP_CLOSE = 1'b1
   } op_type;

   typedef enum logic {
      MODE_LINE   = 1'b0,
      MODE_FRAMED = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_END     = 2'd1,
      KIND_ABORT   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_HDR_LO = 2'd0,
      PH_HDR_HI = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   // One result item
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] len;
   } result_type;

   // Results produced by one item, in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== rtl/bsmd_parse.sv =====
// Parse state and per-item result logic of the deframer.
// Depends on bsmd_pkg for item, phase and result types.
module bsmd_parse #(
   parameter int MaxPayload = bsmd_pkg::MaxPayloadDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_framing_mode,
   input  logic               step,
   input  bsmd_pkg::op_type   op,
   input  logic [7:0]         data,
   output bsmd_pkg::push_type push
);

   localparam int RemW = $clog2(MaxPayload + 1);
   localparam logic [RemW-1:0] RemMax = RemW'(MaxPayload);

   // Parse state
   bsmd_pkg::mode_type  mode_ff, mode_in;
   bsmd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          hdr_lo_ff, hdr_lo_in;
   logic [RemW-1:0]     rem_ff, rem_in;
   logic [15:0]         len_ff, len_in;
   logic                started_ff, started_in;
   logic                cr_ff, cr_in;

   logic [15:0]     hdr_len;
   logic [15:0]     len_p1;
   logic [15:0]     len_p2;
   logic [RemW-1:0] rem_dec;

   assign hdr_len = {data, hdr_lo_ff};
   assign len_p1  = len_ff + 16'd1;
   assign len_p2  = len_ff + 16'd2;
   assign rem_dec = (rem_ff != '0) ? rem_ff - RemW'(1) : '0;

   // Next state and results for one item
   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      hdr_lo_in  = hdr_lo_ff;
      rem_in     = rem_ff;
      len_in     = len_ff;
      started_in = started_ff;
      cr_in      = cr_ff;
      push.count        = 2'd0;
      push.first.kind   = bsmd_pkg::KIND_PAYLOAD;
      push.first.data   = data;
      push.first.len    = 16'd0;
      push.second.kind  = bsmd_pkg::KIND_PAYLOAD;
      push.second.data  = data;
      push.second.len   = 16'd0;

      if (csr_write_enable) begin
         mode_in = bsmd_pkg::mode_type'(csr_framing_mode);
         phase_in   = bsmd_pkg::PH_HDR_LO;
         hdr_lo_in  = 8'd0;
         rem_in     = '0;
         len_in     = 16'd0;
         started_in = 1'b0;
         cr_in      = 1'b0;
      end else if (step) begin
         if (op == bsmd_pkg::OP_CLOSE) begin
            // close: abort a started message, drop everything else
            if (started_ff) begin
               push.count      = 2'd1;
               push.first.kind = bsmd_pkg::KIND_ABORT;
               push.first.data = 8'd0;
            end
            phase_in   = bsmd_pkg::PH_HDR_LO;
            hdr_lo_in  = 8'd0;
            rem_in     = '0;
            len_in     = 16'd0;
            started_in = 1'b0;
            cr_in      = 1'b0;
         end else if (mode_ff == bsmd_pkg::MODE_LINE) begin
            if (data == bsmd_pkg::CharLf) begin
               // end of line; empty lines give nothing
               if (started_ff) begin
                  push.count      = 2'd1;
                  push.first.kind = bsmd_pkg::KIND_END;
                  push.first.data = 8'd0;
                  push.first.len  = len_ff;
               end
               phase_in   = bsmd_pkg::PH_HDR_LO;
               hdr_lo_in  = 8'd0;
               rem_in     = '0;
               len_in     = 16'd0;
               started_in = 1'b0;
               cr_in      = 1'b0;
            end else if (data == bsmd_pkg::CharCr) begin
               // hold this CR, release an earlier one
               if (cr_ff) begin
                  push.count      = 2'd1;
                  push.first.data = bsmd_pkg::CharCr;
                  len_in          = len_p1;
                  started_in      = 1'b1;
               end
               cr_in = 1'b1;
            end else begin
               // ordinary byte, after a released CR if one is held
               if (cr_ff) begin
                  push.count      = 2'd2;
                  push.first.data = bsmd_pkg::CharCr;
                  len_in          = len_p2;
               end else begin
                  push.count = 2'd1;
                  len_in     = len_p1;
               end
               started_in = 1'b1;
               cr_in      = 1'b0;
            end
         end else begin
            case (phase_ff)
               bsmd_pkg::PH_HDR_LO: begin
                  hdr_lo_in = data;
                  phase_in  = bsmd_pkg::PH_HDR_HI;
               end
               bsmd_pkg::PH_HDR_HI: begin
                  // zero length skips straight to the next header
                  if (hdr_len == 16'd0) begin
                     phase_in = bsmd_pkg::PH_HDR_LO;
                  end else begin
                     rem_in   = ({1'b0, hdr_len} <= 17'(MaxPayload)) ?
                                RemW'(hdr_len) : RemMax;
                     len_in   = 16'd0;
                     phase_in = bsmd_pkg::PH_BODY;
                  end
               end
               bsmd_pkg::PH_BODY: begin
                  push.count = 2'd1;
                  if (rem_dec == '0) begin
                     // last delivered byte closes the frame
                     push.count       = 2'd2;
                     push.first.data  = data;
                     push.second.kind = bsmd_pkg::KIND_END;
                     push.second.data = 8'd0;
                     push.second.len  = len_p1;
                     phase_in   = bsmd_pkg::PH_HDR_LO;
                     hdr_lo_in  = 8'd0;
                     rem_in     = '0;
                     len_in     = 16'd0;
                     started_in = 1'b0;
                     cr_in      = 1'b0;
                  end else begin
                     rem_in     = rem_dec;
                     len_in     = len_p1;
                     started_in = 1'b1;
                  end
               end
               default: begin
                  phase_in = bsmd_pkg::PH_HDR_LO;
               end
            endcase
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= bsmd_pkg::MODE_LINE;
         phase_ff   <= bsmd_pkg::PH_HDR_LO;
         hdr_lo_ff  <= 8'd0;
         rem_ff     <= '0;
         len_ff     <= 16'd0;
         started_ff <= 1'b0;
         cr_ff      <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         phase_ff   <= phase_in;
         hdr_lo_ff  <= hdr_lo_in;
         rem_ff     <= rem_in;
         len_ff     <= len_in;
         started_ff <= started_in;
         cr_ff      <= cr_in;
      end
   end

endmodule

// ===== rtl/bsmd_rsp_fifo.sv =====
// Result queue: takes zero, one or two results per cycle, hands out one when popped.
// Depends on bsmd_pkg for the result and push types.
module bsmd_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  bsmd_pkg::push_type   push,
   input  logic                 pop,
   output logic                 not_empty,
   output logic                 has_room,
   output logic [2:0]           level,
   output bsmd_pkg::result_type head
);

   localparam int PtrW = $clog2(bsmd_pkg::RspDepth);

   bsmd_pkg::result_type entry_ff [bsmd_pkg::RspDepth];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic [PtrW-1:0] wr_next;

   assign wr_next   = wr_ff + PtrW'(1);
   assign not_empty = (cnt_ff != 3'd0);
   assign has_room  = (cnt_ff <= 3'(bsmd_pkg::RspDepth - 2));
   assign level     = cnt_ff;
   assign head      = entry_ff[rd_ff];

   // Pointer and count update
   always_comb begin
      wr_in  = wr_ff + PtrW'(push.count);
      rd_in  = pop ? rd_ff + PtrW'(1) : rd_ff;
      cnt_in = cnt_ff + 3'(push.count) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= 3'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

// ===== rtl/byte_stream_message_deframer.sv =====
// Top level of the byte stream message deframer: input register, parser, result queue.
// Depends on bsmd_pkg, bsmd_parse and bsmd_rsp_fifo.
//
// Takes one received byte or close item per cycle unless stalled and turns it into
// payload bytes, end markers carrying the wrapping 16-bit message length, and abort
// markers. csr_framing_mode selects newline-terminated lines (0) or two-byte
// little-endian length framing (1); a write also clears all parse state. An item waits
// in the input register until the queue has room. The sustained rate is one item per
// cycle while results are taken; an item that yields two results (a released CR before
// a byte, or the last byte of a frame with its end marker) is absorbed by a four-entry
// result queue, and req_stall rises only when the queue has fewer than two free entries.
module byte_stream_message_deframer #(
   parameter int MaxPayload = bsmd_pkg::MaxPayloadDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_framing_mode,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_message_length
);

   logic                 in_valid_ff, in_valid_in;
   logic                 in_op_ff;
   logic [7:0]           in_data_ff;
   logic                 step;
   logic                 has_room;
   logic                 not_empty;
   logic [2:0]           level;
   bsmd_pkg::push_type   push;
   bsmd_pkg::result_type head;

   // Item leaves the input register when the queue can take two results
   assign step        = in_valid_ff && has_room;
   assign req_stall   = in_valid_ff && !has_room;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_op_ff   <= req_operation;
         in_data_ff <= req_data_byte;
      end
   end

   bsmd_parse #(
      .MaxPayload(MaxPayload)
   ) u_parse (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_framing_mode (csr_framing_mode),
      .step             (step),
      .op               (bsmd_pkg::op_type'(in_op_ff)),
      .data             (in_data_ff),
      .push             (push)
   );

   bsmd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_valid && !rsp_stall),
      .not_empty (not_empty),
      .has_room  (has_room),
      .level     (level),
      .head      (head)
   );

   // Result port
   assign rsp_valid          = not_empty;
   assign rsp_result_kind    = head.kind;
   assign rsp_payload_byte   = head.data;
   assign rsp_message_length = head.len;

   // Queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      level <= 3'(bsmd_pkg::RspDepth))
      else $error("result queue overflow");

   // Results only appear for items that were processed
   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> step)
      else $error("results pushed without an item");

   // Stall only when the queue is short of space
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (level > 3'(bsmd_pkg::RspDepth - 2)))
      else $error("input stalled with queue space free");

   // A shown result carries a defined kind
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_kind == bsmd_pkg::KIND_PAYLOAD ||
                     rsp_result_kind == bsmd_pkg::KIND_END ||
                     rsp_result_kind == bsmd_pkg::KIND_ABORT))
      else $error("undefined result kind");

endmodule

// ===== tb/tb_byte_stream_message_deframer.sv =====
// Self-checking testbench for byte_stream_message_deframer: line mode and length-framed mode.
// Depends on bsmd_pkg and the RTL. Results are checked in order against a built-in predictor.
module tb_byte_stream_message_deframer;

   // One input item: a received byte or a close
   typedef struct packed {
      bsmd_pkg::op_type op;
      logic [7:0]       value;
   } stream_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic        csr_framing_mode = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_message_length;

   stream_item_type      stream_items[$];
   bsmd_pkg::result_type predicted_results[$];
   stream_item_type      next_item;
   bsmd_pkg::result_type want;
   logic                 req_taken = 1'b0;
   int                   req_idle_pct = 35;
   int                   rsp_idle_pct = 58;
   int                   mismatch_count = 0;

   // Predictor state
   bsmd_pkg::mode_type  frame_mode;
   bsmd_pkg::phase_type parse_step;
   logic [7:0]          hdr_low;
   logic [12:0]         body_left;
   logic [15:0]         msg_count;
   logic                line_open;
   logic                cr_held;

   byte_stream_message_deframer DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_framing_mode   (csr_framing_mode),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_message_length (rsp_message_length)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog
   initial begin
      #8_000_000;
      $display("Mismatches found");
      $finish;
   end

   // ---------------- predictor ----------------

   function automatic void clear_parse();
      parse_step = bsmd_pkg::PH_HDR_LO;
      hdr_low    = 8'h00;
      body_left  = 13'd0;
      msg_count  = 16'd0;
      line_open  = 1'b0;
      cr_held    = 1'b0;
   endfunction

   function automatic void push_result(bsmd_pkg::kind_type k, logic [7:0] d, logic [15:0] l);
      bsmd_pkg::result_type r;
      r.kind = k;
      r.data = d;
      r.len  = l;
      predicted_results.push_back(r);
   endfunction

   function automatic void emit_payload(logic [7:0] d);
      push_result(bsmd_pkg::KIND_PAYLOAD, d, 16'd0);
      msg_count = msg_count + 16'd1;
      line_open = 1'b1;
   endfunction

   // Expected results of one accepted item, in order
   function automatic void deframe_item(bsmd_pkg::op_type op, logic [7:0] d);
      logic [15:0] hdr_len;
      if (op == bsmd_pkg::OP_CLOSE) begin
         if (line_open) push_result(bsmd_pkg::KIND_ABORT, 8'h00, 16'd0);
         clear_parse();
      end else if (frame_mode == bsmd_pkg::MODE_LINE) begin
         if (d == bsmd_pkg::CharLf) begin
            if (line_open) push_result(bsmd_pkg::KIND_END, 8'h00, msg_count);
            clear_parse();
         end else if (d == bsmd_pkg::CharCr) begin
            // a second CR releases the held one and takes its place
            if (cr_held) emit_payload(bsmd_pkg::CharCr);
            cr_held = 1'b1;
         end else begin
            if (cr_held) begin
               emit_payload(bsmd_pkg::CharCr);
               cr_held = 1'b0;
            end
            emit_payload(d);
         end
      end else begin
         case (parse_step)
            bsmd_pkg::PH_HDR_LO: begin
               hdr_low    = d;
               parse_step = bsmd_pkg::PH_HDR_HI;
            end
            bsmd_pkg::PH_HDR_HI: begin
               hdr_len = {d, hdr_low};
               if (hdr_len == 16'd0) begin
                  parse_step = bsmd_pkg::PH_HDR_LO;
               end else begin
                  // long frames are cut at the payload cap
                  body_left = (hdr_len > bsmd_pkg::MaxPayloadDefault) ?
                              13'(bsmd_pkg::MaxPayloadDefault) : hdr_len[12:0];
                  msg_count  = 16'd0;
                  parse_step = bsmd_pkg::PH_BODY;
               end
            end
            default: begin
               emit_payload(d);
               if (body_left != 13'd0) body_left = body_left - 13'd1;
               if (body_left == 13'd0) begin
                  push_result(bsmd_pkg::KIND_END, 8'h00, msg_count);
                  clear_parse();
               end
            end
         endcase
      end
   endfunction

   // ---------------- driver ----------------

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (stream_items.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            next_item = stream_items.pop_front();
            req_valid     <= 1'b1;
            req_operation <= next_item.op;
            req_data_byte <= next_item.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      if (reset) begin
         frame_mode = bsmd_pkg::MODE_LINE;
         clear_parse();
         req_taken <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            frame_mode = bsmd_pkg::mode_type'(csr_framing_mode);
            clear_parse();
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: expected no result, got kind=%0d data=%h len=%0d", $time,
                        rsp_result_kind, rsp_payload_byte, rsp_message_length);
            end else begin
               want = predicted_results.pop_front();
               if (rsp_result_kind !== want.kind || rsp_payload_byte !== want.data ||
                   rsp_message_length !== want.len) begin
                  mismatch_count++;
                  $display("%0t: expected kind=%0d data=%h len=%0d, got kind=%0d data=%h len=%0d",
                           $time, want.kind, want.data, want.len, rsp_result_kind,
                           rsp_payload_byte, rsp_message_length);
               end
            end
         end
         if (req_valid && !req_stall)
            deframe_item(bsmd_pkg::op_type'(req_operation), req_data_byte);
         req_taken <= req_valid && !req_stall;
      end
   end

   // ---------------- stimulus ----------------

   task automatic add_byte(logic [7:0] v);
      stream_item_type it;
      it.op    = bsmd_pkg::OP_BYTE;
      it.value = v;
      stream_items.push_back(it);
   endtask

   task automatic add_close();
      stream_item_type it;
      it.op    = bsmd_pkg::OP_CLOSE;
      it.value = 8'($urandom);
      stream_items.push_back(it);
   endtask

   // Any byte but LF and CR
   function automatic logic [7:0] text_char();
      logic [7:0] v;
      v = 8'($urandom);
      if (v == bsmd_pkg::CharLf || v == bsmd_pkg::CharCr) v = v ^ 8'h80;
      return v;
   endfunction

   // Mostly well-formed lines, with stray closes and CRs
   task automatic gen_lines(int count);
      int base;
      int sel;
      int n;
      base = stream_items.size();
      while (stream_items.size() - base < count) begin
         sel = $urandom_range(99);
         if (sel < 80) begin
            n = $urandom_range(0, 12);
            repeat (n) begin
               if ($urandom_range(15) == 0) add_byte(bsmd_pkg::CharCr);
               else add_byte(text_char());
            end
            if ($urandom_range(1)) add_byte(bsmd_pkg::CharCr);
            if ($urandom_range(9) == 0) add_close();
            else add_byte(bsmd_pkg::CharLf);
         end else if (sel < 88) begin
            add_close();
         end else if (sel < 94) begin
            add_byte(bsmd_pkg::CharCr);
         end else begin
            add_byte(8'($urandom));
         end
      end
   endtask

   // Mostly well-formed frames, some cut by a close, some broken headers
   task automatic gen_frames(int count);
      int base;
      int sel;
      int n;
      int cut;
      base = stream_items.size();
      while (stream_items.size() - base < count) begin
         sel = $urandom_range(99);
         if (sel < 82) begin
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
            add_byte(8'(n));
            add_byte(8'(n >> 8));
            cut = ($urandom_range(11) == 0) ? $urandom_range(0, n) : n + 1;
            for (int i = 0; i < n; i++) begin
               if (i == cut) begin
                  add_close();
                  break;
               end
               add_byte(8'($urandom));
            end
         end else if (sel < 90) begin
            add_close();
         end else begin
            // lone header byte, then a close to get back in step
            add_byte(8'($urandom));
            add_close();
         end
      end
   endtask

   // Wait until everything sent has been taken and every result has come back
   task automatic wait_drained();
      while (stream_items.size() != 0 || req_valid || predicted_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(bsmd_pkg::mode_type m);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_framing_mode <= m;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Line mode after reset: CR before LF dropped, empty line, released CRs,
      // byte extremes, abort, silent close, held CR dropped on close
      add_byte(8'h41); add_byte(bsmd_pkg::CharCr); add_byte(bsmd_pkg::CharLf);
      add_byte(bsmd_pkg::CharLf);
      add_byte(bsmd_pkg::CharCr); add_byte(bsmd_pkg::CharCr); add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(bsmd_pkg::CharCr); add_byte(bsmd_pkg::CharLf);
      add_byte(8'h80); add_close();
      add_close();
      add_byte(bsmd_pkg::CharCr); add_close();
      add_byte(8'h55);              // left open; the mode write drops it
      wait_drained();
      write_mode(bsmd_pkg::MODE_FRAMED);

      // Framed: zero length, one byte, abort mid-body, partial header on close
      add_byte(8'h00); add_byte(8'h00);
      add_byte(8'h01); add_byte(8'h00); add_byte(8'hFF);
      add_byte(8'h02); add_byte(8'h00); add_byte(8'h12); add_close();
      add_byte(8'h07); add_close();
      add_byte(8'h01); add_byte(8'h00); add_byte(bsmd_pkg::CharLf);
      wait_drained();

      // Sender idles less than receiver
      gen_frames(290);
      wait_drained();
      write_mode(bsmd_pkg::MODE_LINE);

      // Receiver idles less than sender
      req_idle_pct = 58;
      rsp_idle_pct = 35;
      gen_lines(290);
      wait_drained();
      write_mode(bsmd_pkg::MODE_FRAMED);

      // No idling, frames then lines
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      gen_frames(170);
      wait_drained();
      write_mode(bsmd_pkg::MODE_LINE);

      gen_lines(170);
      wait_drained();

      if (mismatch_count == 0 && predicted_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
